FILE: sv/srts_pkg.sv
package srts_pkg;

   localparam int NUM_TASKS = 16;
   localparam int IDX_W     = 4;
   localparam int CNT_W     = 5;
   localparam int KEY_W     = 32;
   localparam int TIME_W    = 63;

   localparam logic [TIME_W-1:0] MAX63     = {TIME_W{1'b1}};
   localparam logic [TIME_W-1:0] TICK_NS   = 63'd1000;
   localparam logic [TIME_W-1:0] STEPS_RST = 63'd1000000;

   localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL2   = 64'h94d049bb133111eb;
   localparam logic [63:0] SEED_XOR   = 64'hd1b54a32d192ed03;

   // request op codes
   localparam logic [3:0] OP_START      = 4'd0;
   localparam logic [3:0] OP_POINT      = 4'd1;
   localparam logic [3:0] OP_PARK       = 4'd2;
   localparam logic [3:0] OP_SLEEP      = 4'd3;
   localparam logic [3:0] OP_EXIT       = 4'd4;
   localparam logic [3:0] OP_JOIN       = 4'd5;
   localparam logic [3:0] OP_NOTIFY     = 4'd6;
   localparam logic [3:0] OP_NOTIFY_ONE = 4'd7;
   localparam logic [3:0] OP_WAKE       = 4'd8;
   localparam logic [3:0] OP_SPAWN      = 4'd9;

   // response status codes
   localparam logic [1:0] RES_OK       = 2'd0;
   localparam logic [1:0] RES_DEADLOCK = 2'd1;
   localparam logic [1:0] RES_BUDGET   = 2'd2;
   localparam logic [1:0] RES_FULL     = 2'd3;

   // task states
   localparam logic [1:0] ST_RUNNABLE = 2'd0;
   localparam logic [1:0] ST_PARKED   = 2'd1;
   localparam logic [1:0] ST_SLEEPING = 2'd2;
   localparam logic [1:0] ST_DONE     = 2'd3;

   // register indexes
   localparam logic CSR_SEED      = 1'b0;
   localparam logic CSR_MAX_STEPS = 1'b1;

   // datapath commands
   localparam int CMD_W = 5;
   localparam logic [CMD_W-1:0] CMD_NONE        = 5'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD        = 5'd1;
   localparam logic [CMD_W-1:0] CMD_START_TABLE = 5'd2;
   localparam logic [CMD_W-1:0] CMD_MIX_SEED    = 5'd3;
   localparam logic [CMD_W-1:0] CMD_MIX_RAND    = 5'd4;
   localparam logic [CMD_W-1:0] CMD_TAKE_SEED   = 5'd5;
   localparam logic [CMD_W-1:0] CMD_TAKE_RAND   = 5'd6;
   localparam logic [CMD_W-1:0] CMD_OWN         = 5'd7;
   localparam logic [CMD_W-1:0] CMD_STEP        = 5'd8;
   localparam logic [CMD_W-1:0] CMD_TICK        = 5'd9;
   localparam logic [CMD_W-1:0] CMD_WAKE        = 5'd10;
   localparam logic [CMD_W-1:0] CMD_COUNT_RUN   = 5'd11;
   localparam logic [CMD_W-1:0] CMD_COUNT_KEY   = 5'd12;
   localparam logic [CMD_W-1:0] CMD_PICK_INIT   = 5'd13;
   localparam logic [CMD_W-1:0] CMD_PICK_STEP   = 5'd14;
   localparam logic [CMD_W-1:0] CMD_MIN_INIT    = 5'd15;
   localparam logic [CMD_W-1:0] CMD_MIN_STEP    = 5'd16;
   localparam logic [CMD_W-1:0] CMD_JUMP        = 5'd17;
   localparam logic [CMD_W-1:0] CMD_FAIL_BUDGET = 5'd18;
   localparam logic [CMD_W-1:0] CMD_FAIL_DEAD   = 5'd19;
   localparam logic [CMD_W-1:0] CMD_PUBLISH     = 5'd20;

   typedef struct packed {
      logic [CMD_W-1:0] code;
      logic             key_mode;
   } srts_cmd_type;

   typedef struct packed {
      logic [3:0] op;
      logic       mix_done;
      logic       rem_done;
      logic       n_zero;
      logic       over_budget;
      logic       pick_hit;
      logic       idx_last;
      logic       found;
      logic       cur_ok;
   } srts_stat_type;

endpackage

FILE: sv/srts_mix.sv
module srts_mix (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] state_in,
   output logic        done,
   output logic [63:0] next_state,
   output logic [63:0] value
);
   import srts_pkg::*;

   logic [63:0] s_ff, s_in, a_ff, a_in, acc_ff, acc_in, value_ff, value_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] sum, mulc;
   logic [31:0] opa, opb;
   logic [63:0] prod;

   always_comb begin
      sum  = state_in + MIX_GOLDEN;
      mulc = cnt_ff[2] ? MIX_MUL2 : MIX_MUL1;
      case (cnt_ff[1:0])
         2'd1: begin
            opa = a_ff[31:0];
            opb = mulc[63:32];
         end
         2'd2: begin
            opa = a_ff[63:32];
            opb = mulc[31:0];
         end
         default: begin
            opa = a_ff[31:0];
            opb = mulc[31:0];
         end
      endcase
      prod = {32'd0, opa} * {32'd0, opb};

      s_in     = s_ff;
      a_in     = a_ff;
      acc_in   = acc_ff;
      value_in = value_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         s_in    = sum;
         a_in    = sum ^ (sum >> 30);
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         case (cnt_ff[1:0])
            2'd0:    acc_in = prod;
            2'd3:    a_in = acc_ff ^ (acc_ff >> 27);
            default: acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
         endcase
         if (cnt_ff == 3'd7) begin
            value_in = acc_ff ^ (acc_ff >> 31);
            busy_in  = 1'b0;
            done_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      a_ff     <= a_in;
      acc_ff   <= acc_in;
      value_ff <= value_in;
   end

   assign done       = done_ff;
   assign next_state = s_ff;
   assign value      = value_ff;
endmodule

FILE: sv/srts_rem.sv
module srts_rem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [63:0]                dividend,
   input  logic [srts_pkg::CNT_W-1:0] divisor,
   output logic                       done,
   output logic [srts_pkg::IDX_W-1:0] remainder
);
   import srts_pkg::*;

   logic [63:0]      q_ff, q_in;
   logic [CNT_W-1:0] div_ff, div_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0] r;

   // four quotient bits per cycle, remainder stays below the divisor
   always_comb begin
      q_in    = q_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      r       = '0;
      if (start) begin
         q_in    = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r = {1'b0, rem_ff};
         for (int j = 0; j < 4; j++) begin
            r = {r[IDX_W-1:0], q_ff[63-j]};
            if (r >= div_ff) r = r - div_ff;
         end
         rem_in = r[IDX_W-1:0];
         q_in   = q_ff << 4;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

FILE: sv/srts_dp.sv
module srts_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  srts_pkg::srts_cmd_type      cmd,
   output srts_pkg::srts_stat_type     stat,
   input  logic [3:0]                  req_op,
   input  logic [31:0]                 req_key,
   input  logic [3:0]                  req_target,
   input  logic [62:0]                 req_sleep_ns,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [63:0]                 csr_wdata,
   output logic [1:0]                  rsp_status,
   output logic [3:0]                  rsp_current_task,
   output logic [62:0]                 rsp_now_ns,
   output logic [62:0]                 rsp_step_count,
   output logic [3:0]                  rsp_spawned_index
);
   import srts_pkg::*;

   logic [3:0]        op_ff, op_in, tgt_ff, tgt_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [TIME_W-1:0] ns_ff, ns_in;
   logic [63:0]       seed_ff, seed_in;
   logic [TIME_W-1:0] max_ff, max_in;

   logic [1:0]        st_ff [NUM_TASKS];
   logic [1:0]        st_in [NUM_TASKS];
   logic [KEY_W-1:0]  tkey_ff [NUM_TASKS];
   logic [KEY_W-1:0]  tkey_in [NUM_TASKS];
   logic              kit_ff [NUM_TASKS];
   logic              kit_in [NUM_TASKS];
   logic [TIME_W-1:0] dl_ff [NUM_TASKS];
   logic [TIME_W-1:0] dl_in [NUM_TASKS];

   logic [CNT_W-1:0]  count_ff, count_in, n_ff, n_in;
   logic [IDX_W-1:0]  cur_ff, cur_in, k_ff, k_in, idx_ff, idx_in;
   logic [TIME_W-1:0] step_ff, step_in, time_ff, time_in, early_ff, early_in;
   logic [63:0]       rs_ff, rs_in;
   logic              found_ff, found_in;
   logic [1:0]        res_ff, res_in;
   logic [IDX_W-1:0]  spawned_ff, spawned_in;

   logic [1:0]        o_status_ff;
   logic [IDX_W-1:0]  o_cur_ff, o_spawned_ff;
   logic [TIME_W-1:0] o_now_ff, o_steps_ff;

   logic [NUM_TASKS-1:0] inr, run_m, key_m, tsk_m, due_m;
   logic [CNT_W-1:0]  run_n, key_n;
   logic [63:0]       sleep_sum, tick_sum;
   logic [KEY_W-1:0]  cur_key, tgt_key;
   logic              pick_m, min_c;

   logic              mix_start, mix_done, rem_start, rem_done;
   logic [63:0]       mix_seed, mix_next, mix_val;
   logic [IDX_W-1:0]  rem_val;

   srts_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .start      (mix_start),
      .state_in   (mix_seed),
      .done       (mix_done),
      .next_state (mix_next),
      .value      (mix_val)
   );

   srts_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (mix_val),
      .divisor   (n_ff),
      .done      (rem_done),
      .remainder (rem_val)
   );

   assign cur_key = KEY_W'(cur_ff);
   assign tgt_key = KEY_W'(tgt_ff);

   always_comb begin
      run_n = '0;
      key_n = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         inr[i]   = CNT_W'(i) < count_ff;
         run_m[i] = inr[i] && st_ff[i] == ST_RUNNABLE;
         key_m[i] = inr[i] && st_ff[i] == ST_PARKED && !kit_ff[i] && tkey_ff[i] == key_ff;
         tsk_m[i] = inr[i] && st_ff[i] == ST_PARKED && kit_ff[i] && tkey_ff[i] == cur_key
                    && IDX_W'(i) != cur_ff;
         due_m[i] = inr[i] && st_ff[i] == ST_SLEEPING && dl_ff[i] <= time_ff;
         run_n    = run_n + CNT_W'(run_m[i]);
         key_n    = key_n + CNT_W'(key_m[i]);
      end
   end

   assign sleep_sum = {1'b0, time_ff} + {1'b0, ns_ff};
   assign tick_sum  = {1'b0, time_ff} + {1'b0, TICK_NS};
   assign pick_m    = cmd.key_mode ? key_m[idx_ff] : run_m[idx_ff];
   assign min_c     = inr[idx_ff] && st_ff[idx_ff] == ST_SLEEPING
                      && (!found_ff || dl_ff[idx_ff] < early_ff);

   assign mix_start = cmd.code == CMD_START_TABLE || cmd.code == CMD_MIX_SEED
                      || cmd.code == CMD_MIX_RAND;
   assign mix_seed  = (cmd.code == CMD_MIX_RAND) ? rs_ff : (seed_ff ^ SEED_XOR);
   assign rem_start = cmd.code == CMD_TAKE_RAND;

   always_comb begin
      op_in      = op_ff;
      key_in     = key_ff;
      tgt_in     = tgt_ff;
      ns_in      = ns_ff;
      seed_in    = seed_ff;
      max_in     = max_ff;
      st_in      = st_ff;
      tkey_in    = tkey_ff;
      kit_in     = kit_ff;
      dl_in      = dl_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      step_in    = step_ff;
      time_in    = time_ff;
      rs_in      = rs_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      idx_in     = idx_ff;
      early_in   = early_ff;
      found_in   = found_ff;
      res_in     = res_ff;
      spawned_in = spawned_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SEED:      seed_in = csr_wdata;
            CSR_MAX_STEPS: max_in  = csr_wdata[TIME_W-1:0];
            default:       seed_in = seed_ff;
         endcase
      end

      unique case (cmd.code)
         CMD_LOAD: begin
            op_in      = req_op;
            key_in     = req_key[KEY_W-1:0];
            tgt_in     = req_target;
            ns_in      = req_sleep_ns;
            res_in     = RES_OK;
            spawned_in = '0;
         end
         CMD_START_TABLE: begin
            count_in = CNT_W'(1);
            st_in[0] = ST_RUNNABLE;
            cur_in   = '0;
            step_in  = '0;
            time_in  = '0;
         end
         CMD_TAKE_SEED: rs_in = mix_val;
         CMD_TAKE_RAND: rs_in = mix_next;
         CMD_OWN: begin
            case (op_ff)
               OP_PARK: begin
                  st_in[cur_ff]   = ST_PARKED;
                  tkey_in[cur_ff] = key_ff;
                  kit_in[cur_ff]  = 1'b0;
               end
               OP_SLEEP: begin
                  if (ns_ff != '0) begin
                     st_in[cur_ff] = ST_SLEEPING;
                     dl_in[cur_ff] = sleep_sum[63] ? MAX63 : sleep_sum[TIME_W-1:0];
                  end
               end
               OP_EXIT: begin
                  st_in[cur_ff] = ST_DONE;
                  for (int i = 0; i < NUM_TASKS; i++)
                     if (tsk_m[i]) st_in[i] = ST_RUNNABLE;
               end
               OP_JOIN: begin
                  if (inr[tgt_ff] && st_ff[tgt_ff] != ST_DONE) begin
                     st_in[cur_ff]   = ST_PARKED;
                     tkey_in[cur_ff] = tgt_key;
                     kit_in[cur_ff]  = 1'b1;
                  end
               end
               OP_NOTIFY: begin
                  for (int i = 0; i < NUM_TASKS; i++)
                     if (key_m[i]) st_in[i] = ST_RUNNABLE;
               end
               OP_WAKE: begin
                  if (inr[tgt_ff] && st_ff[tgt_ff] == ST_SLEEPING)
                     st_in[tgt_ff] = ST_RUNNABLE;
               end
               OP_SPAWN: begin
                  if (count_ff >= CNT_W'(NUM_TASKS)) begin
                     res_in = RES_FULL;
                  end else begin
                     st_in[count_ff[IDX_W-1:0]] = ST_RUNNABLE;
                     spawned_in = count_ff[IDX_W-1:0];
                     count_in   = count_ff + CNT_W'(1);
                  end
               end
               default: res_in = res_ff;
            endcase
         end
         CMD_STEP: step_in = (step_ff == MAX63) ? step_ff : step_ff + TIME_W'(1);
         CMD_TICK: time_in = tick_sum[63] ? MAX63 : tick_sum[TIME_W-1:0];
         CMD_WAKE: begin
            for (int i = 0; i < NUM_TASKS; i++)
               if (due_m[i]) st_in[i] = ST_RUNNABLE;
         end
         CMD_COUNT_RUN: n_in = run_n;
         CMD_COUNT_KEY: n_in = key_n;
         CMD_PICK_INIT: begin
            k_in   = rem_val;
            idx_in = '0;
         end
         CMD_PICK_STEP: begin
            if (pick_m) begin
               if (k_ff == '0) begin
                  if (cmd.key_mode) st_in[idx_ff] = ST_RUNNABLE;
                  else              cur_in = idx_ff;
               end else begin
                  k_in = k_ff - IDX_W'(1);
               end
            end
            idx_in = idx_ff + IDX_W'(1);
         end
         CMD_MIN_INIT: begin
            found_in = 1'b0;
            idx_in   = '0;
         end
         CMD_MIN_STEP: begin
            if (min_c) begin
               early_in = dl_ff[idx_ff];
               found_in = 1'b1;
            end
            idx_in = idx_ff + IDX_W'(1);
         end
         CMD_JUMP: if (early_ff > time_ff) time_in = early_ff;
         CMD_FAIL_BUDGET: res_in = RES_BUDGET;
         CMD_FAIL_DEAD:   res_in = RES_DEADLOCK;
         default: res_in = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         max_ff   <= STEPS_RST;
         count_ff <= CNT_W'(1);
         cur_ff   <= '0;
         step_ff  <= '0;
         time_ff  <= '0;
         rs_ff    <= '0;
         for (int i = 0; i < NUM_TASKS; i++) st_ff[i] <= ST_RUNNABLE;
      end else begin
         seed_ff  <= seed_in;
         max_ff   <= max_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
         step_ff  <= step_in;
         time_ff  <= time_in;
         rs_ff    <= rs_in;
         st_ff    <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      tgt_ff     <= tgt_in;
      ns_ff      <= ns_in;
      tkey_ff    <= tkey_in;
      kit_ff     <= kit_in;
      dl_ff      <= dl_in;
      n_ff       <= n_in;
      k_ff       <= k_in;
      idx_ff     <= idx_in;
      early_ff   <= early_in;
      found_ff   <= found_in;
      res_ff     <= res_in;
      spawned_ff <= spawned_in;
      if (cmd.code == CMD_PUBLISH) begin
         o_status_ff  <= res_ff;
         o_cur_ff     <= cur_ff;
         o_now_ff     <= time_ff;
         o_steps_ff   <= step_ff;
         o_spawned_ff <= spawned_ff;
      end
   end

   always_comb begin
      stat.op          = op_ff;
      stat.mix_done    = mix_done;
      stat.rem_done    = rem_done;
      stat.n_zero      = n_ff == '0;
      stat.over_budget = step_ff > max_ff;
      stat.pick_hit    = pick_m && k_ff == '0;
      stat.idx_last    = idx_ff == IDX_W'(NUM_TASKS - 1);
      stat.found       = found_ff;
      stat.cur_ok      = CNT_W'(cur_ff) < count_ff;
   end

   assign rsp_status        = o_status_ff;
   assign rsp_current_task  = o_cur_ff;
   assign rsp_now_ns        = o_now_ff;
   assign rsp_step_count    = o_steps_ff;
   assign rsp_spawned_index = o_spawned_ff;
endmodule

FILE: sv/srts_ctrl.sv
module srts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  srts_pkg::srts_stat_type stat,
   output srts_pkg::srts_cmd_type  cmd
);
   import srts_pkg::*;

   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_INIT_W   = 4'd1;
   localparam logic [3:0] S_IDLE     = 4'd2;
   localparam logic [3:0] S_DISPATCH = 4'd3;
   localparam logic [3:0] S_START_W  = 4'd4;
   localparam logic [3:0] S_STEP     = 4'd5;
   localparam logic [3:0] S_CHECK    = 4'd6;
   localparam logic [3:0] S_WAKE     = 4'd7;
   localparam logic [3:0] S_COUNT    = 4'd8;
   localparam logic [3:0] S_ZERO     = 4'd9;
   localparam logic [3:0] S_MIX_W    = 4'd10;
   localparam logic [3:0] S_REM_W    = 4'd11;
   localparam logic [3:0] S_PICK     = 4'd12;
   localparam logic [3:0] S_MIN      = 4'd13;
   localparam logic [3:0] S_JUMP     = 4'd14;
   localparam logic [3:0] S_FINISH   = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       mode_ff, mode_in, second_ff, second_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       publish;

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      second_in = second_ff;
      cmd.code  = CMD_NONE;
      publish   = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.code = CMD_MIX_SEED;
            state_in = S_INIT_W;
         end
         S_INIT_W: begin
            if (stat.mix_done) begin
               cmd.code = CMD_TAKE_SEED;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.code = CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.op) inside
               OP_START: begin
                  cmd.code = CMD_START_TABLE;
                  state_in = S_START_W;
               end
               OP_POINT, OP_PARK, OP_SLEEP, OP_EXIT, OP_JOIN: begin
                  cmd.code = CMD_OWN;
                  state_in = S_STEP;
               end
               OP_NOTIFY_ONE: begin
                  cmd.code = CMD_COUNT_KEY;
                  mode_in  = 1'b1;
                  state_in = S_ZERO;
               end
               default: begin
                  cmd.code = CMD_OWN;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_START_W: begin
            if (stat.mix_done) begin
               cmd.code = CMD_TAKE_SEED;
               state_in = S_FINISH;
            end
         end
         S_STEP: begin
            cmd.code = CMD_STEP;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.over_budget) begin
               cmd.code = CMD_FAIL_BUDGET;
               state_in = S_FINISH;
            end else begin
               cmd.code  = CMD_TICK;
               second_in = 1'b0;
               state_in  = S_WAKE;
            end
         end
         S_WAKE: begin
            cmd.code = CMD_WAKE;
            state_in = S_COUNT;
         end
         S_COUNT: begin
            cmd.code = CMD_COUNT_RUN;
            mode_in  = 1'b0;
            state_in = S_ZERO;
         end
         S_ZERO: begin
            if (!stat.n_zero) begin
               cmd.code = CMD_MIX_RAND;
               state_in = S_MIX_W;
            end else if (mode_ff) begin
               state_in = S_FINISH;
            end else if (!second_ff) begin
               cmd.code = CMD_MIN_INIT;
               state_in = S_MIN;
            end else begin
               cmd.code = CMD_FAIL_DEAD;
               state_in = S_FINISH;
            end
         end
         S_MIX_W: begin
            if (stat.mix_done) begin
               cmd.code = CMD_TAKE_RAND;
               state_in = S_REM_W;
            end
         end
         S_REM_W: begin
            if (stat.rem_done) begin
               cmd.code = CMD_PICK_INIT;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            cmd.code = CMD_PICK_STEP;
            if (stat.pick_hit) state_in = S_FINISH;
         end
         S_MIN: begin
            cmd.code = CMD_MIN_STEP;
            if (stat.idx_last) state_in = S_JUMP;
         end
         S_JUMP: begin
            if (!stat.found) begin
               cmd.code = CMD_FAIL_DEAD;
               state_in = S_FINISH;
            end else begin
               cmd.code  = CMD_JUMP;
               second_in = 1'b1;
               state_in  = S_WAKE;
            end
         end
         S_FINISH: begin
            // hand off to the response register once it is empty or its response is being taken
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.code = CMD_PUBLISH;
               publish  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.key_mode = mode_ff;
      rsp_valid_in = (rsp_valid_ff & rsp_stall) | publish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         mode_ff      <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
endmodule

FILE: sv/seeded_random_task_scheduler_core.sv
// Seeded random task scheduler: a 16-entry task table with one current task,
// driven one request at a time.
// Table-only requests are notify, wake, spawn and unused codes.
// Start includes one splitmix64 pass on the shared 32x32 multiplier and the
// pickup of its result.
// A scheduling request covers the own state change, step and budget check,
// tick, wake and count, one splitmix64 pass, the modulo unit (four bits per
// cycle) and a scan of up to 16 entries for the chosen task. When nothing is
// runnable, a 16-entry scan for the earliest deadline is added. A deadlock
// with no sleeper answers after that scan, and an over-budget step after the
// budget check.
// notify_one ends early when no task waits on the key.
// After reset the block derives the random stream before it takes the first
// request.
// A new request is taken while the previous response still waits in the
// output register. A finished request holds until that register frees.
module seeded_random_task_scheduler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_op,
   input  logic [31:0] req_key,
   input  logic [3:0]  req_target,
   input  logic [62:0] req_sleep_ns,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_current_task,
   output logic [62:0] rsp_now_ns,
   output logic [62:0] rsp_step_count,
   output logic [3:0]  rsp_spawned_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);
   import srts_pkg::*;

   srts_cmd_type  cmd;
   srts_stat_type stat;

   assign csr_ready = 1'b1;

   srts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   srts_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_key           (req_key),
      .req_target        (req_target),
      .req_sleep_ns      (req_sleep_ns),
      .csr_we            (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_status        (rsp_status),
      .rsp_current_task  (rsp_current_task),
      .rsp_now_ns        (rsp_now_ns),
      .rsp_step_count    (rsp_step_count),
      .rsp_spawned_index (rsp_spawned_index)
   );

   a_cur_in_table: assert property (@(posedge clock) disable iff (reset) stat.cur_ok)
      else $error("current task outside the task table");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(stat.mix_done && stat.rem_done))
      else $error("mixer and modulo unit finished together");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while the previous one is still in work");
endmodule

FILE: verif/seeded_random_task_scheduler_core_tb.sv
module seeded_random_task_scheduler_core_tb;
   import srts_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  current_task;
      logic [62:0] now_ns;
      logic [62:0] step_count;
      logic [3:0]  spawned_index;
   } sched_rsp_type;

   class sched_scoreboard;
      logic [63:0] seed;
      logic [62:0] step_budget;
      logic [1:0]  tstat [NUM_TASKS];
      logic [31:0] tkey [NUM_TASKS];
      logic        tkey_task [NUM_TASKS];
      logic [62:0] tdead [NUM_TASKS];
      int          tcount;
      int          cur;
      logic [62:0] steps;
      logic [62:0] now;
      logic [63:0] rnd;
      sched_rsp_type pending[$];
      int          errors;

      function void clear();
         seed = 64'd0;
         step_budget = STEPS_RST;
         errors = 0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            tstat[i] = ST_RUNNABLE;
            tkey[i] = 0;
            tkey_task[i] = 0;
            tdead[i] = 0;
         end
         restart();
      endfunction

      function logic [63:0] splitmix(inout logic [63:0] s);
         logic [63:0] z;
         s = s + MIX_GOLDEN;
         z = s;
         z = (z ^ (z >> 30)) * MIX_MUL1;
         z = (z ^ (z >> 27)) * MIX_MUL2;
         return z ^ (z >> 31);
      endfunction

      function logic [62:0] sat_add(logic [62:0] a, logic [62:0] b);
         return (b > MAX63 - a) ? MAX63 : a + b;
      endfunction

      function void restart();
         logic [63:0] s;
         tcount = 1;
         tstat[0] = ST_RUNNABLE;
         cur = 0;
         steps = 0;
         now = 0;
         s = seed ^ SEED_XOR;
         rnd = splitmix(s);
      endfunction

      function void wake_due();
         for (int i = 0; i < tcount; i++)
            if (tstat[i] == ST_SLEEPING && tdead[i] <= now) tstat[i] = ST_RUNNABLE;
      endfunction

      function int pick();
         int n;
         logic [63:0] k;
         n = 0;
         for (int i = 0; i < tcount; i++) if (tstat[i] == ST_RUNNABLE) n++;
         if (n == 0) return -1;
         k = splitmix(rnd) % n;
         for (int i = 0; i < tcount; i++) begin
            if (tstat[i] != ST_RUNNABLE) continue;
            if (k == 0) return i;
            k--;
         end
         return -1;
      endfunction

      function logic [1:0] schedule();
         int nxt;
         logic found;
         logic [62:0] early;
         steps = sat_add(steps, 1);
         if (steps > step_budget) return RES_BUDGET;
         now = sat_add(now, TICK_NS);
         wake_due();
         nxt = pick();
         if (nxt < 0) begin
            found = 0;
            early = 0;
            for (int i = 0; i < tcount; i++)
               if (tstat[i] == ST_SLEEPING && (!found || tdead[i] < early)) begin
                  early = tdead[i];
                  found = 1;
               end
            if (found) begin
               if (early > now) now = early;
               wake_due();
               nxt = pick();
            end
         end
         if (nxt < 0) return RES_DEADLOCK;
         cur = nxt;
         return RES_OK;
      endfunction

      function void park(logic [31:0] k, logic is_task);
         tstat[cur] = ST_PARKED;
         tkey[cur] = k;
         tkey_task[cur] = is_task;
      endfunction

      function void release_all(logic [31:0] k, logic is_task);
         for (int i = 0; i < tcount; i++)
            if (tstat[i] == ST_PARKED && tkey_task[i] == is_task && tkey[i] == k)
               tstat[i] = ST_RUNNABLE;
      endfunction

      function void release_single(logic [31:0] k);
         int n;
         logic [63:0] p;
         n = 0;
         for (int i = 0; i < tcount; i++)
            if (tstat[i] == ST_PARKED && !tkey_task[i] && tkey[i] == k) n++;
         if (n == 0) return;
         p = splitmix(rnd) % n;
         for (int i = 0; i < tcount; i++) begin
            if (tstat[i] != ST_PARKED || tkey_task[i] || tkey[i] != k) continue;
            if (p == 0) begin
               tstat[i] = ST_RUNNABLE;
               return;
            end
            p--;
         end
      endfunction

      function void note_request(logic [3:0] op, logic [31:0] key, logic [3:0] tgt,
                                 logic [62:0] ns);
         sched_rsp_type r;
         r = '0;
         case (op)
            OP_START: restart();
            OP_POINT: r.status = schedule();
            OP_PARK: begin
               park(key, 0);
               r.status = schedule();
            end
            OP_SLEEP: begin
               if (ns > 0) begin
                  tstat[cur] = ST_SLEEPING;
                  tdead[cur] = sat_add(now, ns);
               end
               r.status = schedule();
            end
            OP_EXIT: begin
               tstat[cur] = ST_DONE;
               release_all(cur, 1);
               r.status = schedule();
            end
            OP_JOIN: begin
               if (tgt < tcount && tstat[tgt] != ST_DONE) park(tgt, 1);
               r.status = schedule();
            end
            OP_NOTIFY: release_all(key, 0);
            OP_NOTIFY_ONE: release_single(key);
            OP_WAKE: if (tgt < tcount && tstat[tgt] == ST_SLEEPING) tstat[tgt] = ST_RUNNABLE;
            OP_SPAWN: begin
               if (tcount >= NUM_TASKS) r.status = RES_FULL;
               else begin
                  tstat[tcount] = ST_RUNNABLE;
                  r.spawned_index = tcount;
                  tcount++;
               end
            end
            default: ;
         endcase
         r.current_task = cur;
         r.now_ns = now;
         r.step_count = steps;
         pending.push_back(r);
      endfunction

      function void check_response(sched_rsp_type got);
         sched_rsp_type x;
         if (pending.size() == 0) begin
            $error("unexpected response");
            errors++;
            return;
         end
         x = pending.pop_front();
         if (got.status !== x.status) begin
            $error("status exp %0d got %0d", x.status, got.status);
            errors++;
         end
         if (got.current_task !== x.current_task) begin
            $error("current_task exp %0d got %0d", x.current_task, got.current_task);
            errors++;
         end
         if (got.now_ns !== x.now_ns) begin
            $error("now_ns exp %0d got %0d", x.now_ns, got.now_ns);
            errors++;
         end
         if (got.step_count !== x.step_count) begin
            $error("step_count exp %0d got %0d", x.step_count, got.step_count);
            errors++;
         end
         if (got.spawned_index !== x.spawned_index) begin
            $error("spawned_index exp %0d got %0d", x.spawned_index, got.spawned_index);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [3:0]  req_op = 0;
   logic [31:0] req_key = 0;
   logic [3:0]  req_target = 0;
   logic [62:0] req_sleep_ns = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_current_task;
   logic [62:0] rsp_now_ns;
   logic [62:0] rsp_step_count;
   logic [3:0]  rsp_spawned_index;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_index = 0;
   logic [63:0] csr_wdata = 0;

   sched_scoreboard sched = new();
   longint cycles = 0;
   int     stall_mode = 0;

   seeded_random_task_scheduler_core dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 4000000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stall pattern: phases of none, sparse random, or mostly stalled
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sched.check_response({rsp_status, rsp_current_task, rsp_now_ns,
                               rsp_step_count, rsp_spawned_index});
      if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   task automatic send(logic [3:0] op, logic [31:0] key, logic [3:0] tgt, logic [62:0] ns);
      req_valid <= 1;
      req_op <= op;
      req_key <= key;
      req_target <= tgt;
      req_sleep_ns <= ns;
      do @(posedge clock); while (req_stall);
      sched.note_request(op, key, tgt, ns);
   endtask

   task automatic pause(int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sched.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_SEED) sched.seed = val;
      else sched.step_budget = val[62:0];
   endtask

   function automatic logic [62:0] rand_ns();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return MAX63 - $urandom_range(0, 3);
         2: return {$urandom, $urandom} >> 1;
         default: return $urandom_range(1, 5000);
      endcase
   endfunction

   task automatic random_item();
      int r;
      logic [31:0] key;
      r = $urandom_range(0, 99);
      key = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
      if (r < 2) send(OP_START, $urandom, $urandom, rand_ns());
      else if (r < 22) send(OP_POINT, $urandom, $urandom, rand_ns());
      else if (r < 32) send(OP_PARK, key, $urandom, rand_ns());
      else if (r < 45) send(OP_SLEEP, key, $urandom, rand_ns());
      else if (r < 50) send(OP_EXIT, key, $urandom, rand_ns());
      else if (r < 56) send(OP_JOIN, key, $urandom, rand_ns());
      else if (r < 64) send(OP_NOTIFY, key, $urandom, rand_ns());
      else if (r < 74) send(OP_NOTIFY_ONE, key, $urandom, rand_ns());
      else if (r < 81) send(OP_WAKE, key, $urandom, rand_ns());
      else if (r < 98) send(OP_SPAWN, key, $urandom, rand_ns());
      else send($urandom_range(10, 15), $urandom, $urandom, {$urandom, $urandom});
   endtask

   initial begin
      int burst;
      sched.clear();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      send(OP_POINT, 0, 0, 0);
      send(OP_SPAWN, 0, 0, 0);
      send(OP_SPAWN, 0, 0, 0);
      send(OP_SLEEP, 0, 0, MAX63);
      send(OP_PARK, 32'hffffffff, 0, 0);
      send(OP_NOTIFY_ONE, 32'hffffffff, 0, 0);
      send(OP_WAKE, 0, 4'hf, 0);
      send(OP_JOIN, 0, 4'hf, 0);
      send(OP_JOIN, 0, 0, 0);
      send(OP_NOTIFY, 32'hffffffff, 0, 0);
      send(OP_EXIT, 0, 0, 0);
      send(OP_POINT, 0, 0, 63'd5);
      for (int i = 0; i < 14; i++) send(OP_SPAWN, 0, 0, 0);
      send(4'hf, 32'hffffffff, 4'hf, MAX63);
      for (int i = 0; i < 4; i++) send(OP_PARK, 7, 0, 0);
      drain();
      send(OP_START, 0, 0, 0);
      send(OP_EXIT, 0, 0, 0);
      send(OP_START, 0, 0, 0);
      send(OP_SLEEP, 0, 0, 63'd3);
      drain();

      write_csr(CSR_MAX_STEPS, 64'd3);
      write_csr(CSR_SEED, 64'hffffffffffffffff);
      send(OP_START, 0, 0, 0);
      for (int i = 0; i < 5; i++) send(OP_POINT, 0, 0, 0);
      drain();
      write_csr(CSR_MAX_STEPS, 64'hffffffffffffffff);

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_SEED, (ph == 0) ? 64'd0 : {$urandom, $urandom});
         if (ph == 3) write_csr(CSR_MAX_STEPS, 64'd0);
         if (ph == 4) write_csr(CSR_MAX_STEPS, 64'd150);
         if (ph == 5) write_csr(CSR_MAX_STEPS, STEPS_RST);
         send(OP_START, 0, 0, 0);
         for (int n = 0; n < 280;) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst; b++) random_item();
            n += burst;
            if ($urandom_range(0, 1)) pause($urandom_range(1, 60));
         end
         drain();
      end

      if (sched.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
